// ===== rtl/core/svhm_pkg.sv =====
// ----------------------------------------------------------------------------
// svhm_pkg: shared types and constants of the signed value histogram
// Bin geometry, field widths, command and register codes, and the structs
// that run between the control logic and the moments unit.
// ----------------------------------------------------------------------------
package svhm_pkg;

	// histogram geometry
	localparam int NUM_BINS  = 400;
	localparam int HALF_BINS = NUM_BINS / 2;
	localparam int BIN_W     = $clog2(NUM_BINS);
	localparam int NZ_W      = $clog2(NUM_BINS + 1);

	// field widths
	localparam int CMD_W     = 2;
	localparam int SMP_W     = 16;
	localparam int BKT_W     = 6;
	localparam int CNT_W     = 16;
	localparam int CTR_OUT_W = 16;
	localparam int SUM_W     = 32;
	localparam int SQ_W      = 40;
	localparam int DIST_W    = 9;

	// configuration port
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	// binned value: rounding can push a magnitude slightly past the input range
	localparam int VAL_W     = SMP_W + 2;
	localparam int MAG_W     = SMP_W + 1;

	// shared divider
	localparam int DIV_W     = 16;
	localparam int DVS_W     = CFG_W;

	// bucket address walk reaches past the last bin by up to a full bucket
	localparam int SPAN_W    = $clog2(NUM_BINS + (2 ** BKT_W) * (2 ** CFG_W));
	localparam int CTR_W     = SPAN_W + 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR       = 2'd0,
		CMD_ADD         = 2'd1,
		CMD_READ_BIN    = 2'd2,
		CMD_READ_BUCKET = 2'd3
	} cmd_e_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROUND_ENABLE = 2'd0,
		CFG_ROUND_STEP   = 2'd1,
		CFG_BUCKET_WIDTH = 2'd2
	} cfg_idx_e_t;

	// request into the moments unit
	typedef struct packed {
		logic                    clear;
		logic                    add;
		logic signed [VAL_W-1:0] value;
	} mom_upd_t;

	// running totals out of the moments unit
	typedef struct packed {
		logic        [CNT_W-1:0] count;
		logic signed [SUM_W-1:0] sum;
		logic        [SQ_W-1:0]  square;
	} mom_tot_t;

	// saturating add of two counts
	function automatic logic [CNT_W-1:0] sat_add_cnt(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

// ===== rtl/core/svhm_ram.sv =====
// ----------------------------------------------------------------------------
// svhm_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module svhm_ram #(
	parameter int DEPTH = 400,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/svhm_div.sv =====
// ----------------------------------------------------------------------------
// svhm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; shared by the rounding
// path and the bucket layout computation.
// ----------------------------------------------------------------------------
module svhm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [svhm_pkg::DIV_W-1:0] dividend,
	input  logic [svhm_pkg::DVS_W-1:0] divisor,
	output logic                      busy,
	output logic [svhm_pkg::DIV_W-1:0] quotient,
	output logic [svhm_pkg::DVS_W-1:0] remainder
);
	import svhm_pkg::*;

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  work_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;

	logic [DVS_W:0]    part;
	logic              fits;
	logic [DVS_W:0]    diff;

	// one trial subtraction per cycle
	always_comb begin
		part = {rem_q, work_q[DIV_W-1]};
		fits = part >= {1'b0, dvs_q};
		diff = part - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			work_q <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIV_W);
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DIV_W-2:0], fits};
			rem_q  <= fits ? diff[DVS_W-1:0] : part[DVS_W-1:0];
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy      = busy_q;
	assign quotient  = work_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/svhm_moments.sv =====
// ----------------------------------------------------------------------------
// svhm_moments: running count, sum and sum of squares
// Two stages: square of the binned value, then saturating accumulation.
// Totals reflect an add once it has passed the square and accumulation stages.
// ----------------------------------------------------------------------------
module svhm_moments (
	input  logic               clk,
	input  logic               arst_n,
	input  svhm_pkg::mom_upd_t upd,
	output svhm_pkg::mom_tot_t tot
);
	import svhm_pkg::*;

	logic                    add_s1;
	logic signed [VAL_W-1:0] val_s1;
	logic [2*MAG_W-1:0]      sq_s1;

	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         square_q;

	logic [MAG_W-1:0]        mag;
	logic signed [SUM_W+1:0] sum_ext;
	logic [SQ_W:0]           sq_ext;

	always_comb begin
		mag     = upd.value[VAL_W-1] ? MAG_W'(-upd.value) : MAG_W'(upd.value);
		sum_ext = (SUM_W+2)'(sum_q) + (SUM_W+2)'(val_s1);
		sq_ext  = {1'b0, square_q} + (SQ_W+1)'(sq_s1);
	end

	// stage 1: square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s1 <= 1'b0;
			val_s1 <= '0;
			sq_s1  <= '0;
		end else begin
			add_s1 <= upd.add && !upd.clear;
			val_s1 <= upd.value;
			sq_s1  <= mag * mag;
		end
	end

	// stage 2: saturating accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_q    <= '0;
			square_q <= '0;
		end else if (upd.clear) begin
			count_q  <= '0;
			sum_q    <= '0;
			square_q <= '0;
		end else if (add_s1) begin
			if (count_q != CNT_MAX) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (sum_ext[SUM_W+1:SUM_W-1] != {3{sum_ext[SUM_W+1]}}) begin
				sum_q <= sum_ext[SUM_W+1] ? {1'b1, {(SUM_W-1){1'b0}}}
					: {1'b0, {(SUM_W-1){1'b1}}};
			end else begin
				sum_q <= sum_ext[SUM_W-1:0];
			end
			square_q <= sq_ext[SQ_W] ? {SQ_W{1'b1}} : sq_ext[SQ_W-1:0];
		end
	end

	assign tot.count  = count_q;
	assign tot.sum    = sum_q;
	assign tot.square = square_q;

endmodule

// ===== rtl/core/signed_value_histogram_with_moments_unit.sv =====
// ----------------------------------------------------------------------------
// signed_value_histogram_with_moments_unit: histogram with running moments
// Bin counts in one RAM, totals in a moments unit, a shared divider for
// rounding and bucket layout, and a sequencer with an output register.
// ----------------------------------------------------------------------------
// One command is in work at a time; the input stalls until it has finished,
// while an earlier result may still sit in the output register. Work per
// command: add or read bin reads one bin RAM entry, and an add writes it back
// incremented; an add with rounding first runs the 16-step divider and a
// scaling multiply; read bucket runs the divider, then one bin RAM read per
// bin (a zero width counts as one); clear writes one bin RAM entry per cycle.
// After reset a clearing pass over all NUM_BINS (400) entries runs before
// the first input transfer.
module signed_value_histogram_with_moments_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [svhm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [svhm_pkg::CFG_W-1:0]          cfg_data,
	// command channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [svhm_pkg::CMD_W-1:0]          command,
	input  logic signed [svhm_pkg::SMP_W-1:0]   sample_value,
	input  logic [svhm_pkg::BKT_W-1:0]          bucket_number,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [svhm_pkg::CNT_W-1:0]          bin_or_bucket_count,
	output logic signed [svhm_pkg::CTR_OUT_W-1:0] bucket_center,
	output logic                                out_of_range,
	output logic [svhm_pkg::CNT_W-1:0]          total_count,
	output logic signed [svhm_pkg::SUM_W-1:0]   value_sum,
	output logic [svhm_pkg::SQ_W-1:0]           square_sum,
	output logic [svhm_pkg::DIST_W-1:0]         distinct_bins
);
	import svhm_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_SCALE,
		ST_ADDR,
		ST_RMW,
		ST_BKT,
		ST_SUM,
		ST_DRAIN,
		ST_DONE
	} state_e_t;

	localparam logic signed [VAL_W-1:0] HALF_V = VAL_W'(HALF_BINS);
	localparam logic signed [VAL_W-1:0] NUM_V  = VAL_W'(NUM_BINS);

	// configuration registers
	logic             round_enable_q;
	logic [CFG_W-1:0] round_step_q;
	logic [CFG_W-1:0] bucket_width_q;

	// sequencer and datapath registers
	state_e_t                  state_q;
	cmd_e_t                    cmd_q;
	logic                      report_q;
	logic [BIN_W-1:0]          clr_ptr_q;
	logic signed [VAL_W-1:0]   val_q;
	logic [BKT_W-1:0]          bucket_q;
	logic [BIN_W-1:0]          bin_q;
	logic [SPAN_W-1:0]         addr_q;
	logic [CFG_W-1:0]          left_q;
	logic                      take_s1;
	logic [CNT_W-1:0]          acc_q;
	logic [NZ_W-1:0]           nz_q;
	logic [CNT_W-1:0]          res_count_q;
	logic signed [CTR_OUT_W-1:0] res_center_q;
	logic                      res_oor_q;

	// output register
	logic                      out_valid_q;
	logic [CNT_W-1:0]          out_count_q;
	logic signed [CTR_OUT_W-1:0] out_center_q;
	logic                      out_oor_q;
	logic [CNT_W-1:0]          out_total_q;
	logic signed [SUM_W-1:0]   out_sum_q;
	logic [SQ_W-1:0]           out_square_q;
	logic [DIST_W-1:0]         out_dist_q;

	// bin RAM
	logic             ram_we;
	logic [BIN_W-1:0] ram_waddr;
	logic [CNT_W-1:0] ram_wdata;
	logic             ram_re;
	logic [BIN_W-1:0] ram_raddr;
	logic [CNT_W-1:0] ram_rdata;

	// divider
	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic             div_busy;
	logic [DIV_W-1:0] div_quo;
	logic [DVS_W-1:0] div_rem;

	// moments
	mom_upd_t mom_upd;
	mom_tot_t mom_tot;

	// combinational helpers
	cmd_e_t                  cmd_in;
	logic                    accept;
	logic                    out_free;
	logic signed [MAG_W-1:0] v17;
	logic [MAG_W-1:0]        mag_in;
	logic [CFG_W-1:0]        step_eff;
	logic [CFG_W-1:0]        width_eff;
	logic                    need_round;
	logic signed [VAL_W-1:0] bin_sum;
	logic                    bin_ok;
	logic [BIN_W-1:0]        bin_idx;
	logic [CNT_W-1:0]        bin_inc;
	logic [DIV_W+CFG_W-1:0]  scale_prod;
	logic [VAL_W-1:0]        scale_mag;
	logic [DIV_W-1:0]        nneg;
	logic [DIV_W-1:0]        npos;
	logic [DIV_W-1:0]        bkt_ext;
	logic [DIV_W-1:0]        kpos;
	logic                    is_neg;
	logic                    is_pos;
	logic [SPAN_W-1:0]       bkt_start;
	logic signed [CTR_W-1:0] bkt_center;

	assign cmd_in   = cmd_e_t'(command);
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// input decode, rounding operands
	always_comb begin
		v17        = MAG_W'(sample_value);
		mag_in     = v17[MAG_W-1] ? MAG_W'(-v17) : MAG_W'(v17);
		step_eff   = (round_step_q < CFG_W'(2)) ? CFG_W'(2) : round_step_q;
		width_eff  = (bucket_width_q == '0) ? CFG_W'(1) : bucket_width_q;
		need_round = round_enable_q && (sample_value != '0);
	end

	// divider launch: rounding numerator or the bucket layout split
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_W'(HALF_BINS - 1);
		div_divisor  = width_eff;
		if (cmd_in == CMD_ADD) begin
			div_dividend = DIV_W'(mag_in + MAG_W'(step_eff >> 1) - MAG_W'(1));
			div_divisor  = step_eff;
		end
		if (accept) begin
			div_start = ((cmd_in == CMD_ADD) && need_round) || (cmd_in == CMD_READ_BUCKET);
		end
	end

	// bin index and rounding scale
	always_comb begin
		bin_sum    = val_q + HALF_V;
		bin_ok     = (bin_sum >= 0) && (bin_sum < NUM_V);
		bin_idx    = bin_sum[BIN_W-1:0];
		bin_inc    = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + CNT_W'(1);
		scale_prod = div_quo * (DIV_W+CFG_W)'(step_eff);
		scale_mag  = VAL_W'(scale_prod[MAG_W-1:0]);
	end

	// bucket layout: negative side first, then upward from the center bin
	always_comb begin
		nneg       = div_quo + DIV_W'(div_rem != '0);
		npos       = (HALF_BINS > int'(width_eff)) ? div_quo : '0;
		bkt_ext    = DIV_W'(bucket_q);
		is_neg     = bkt_ext < nneg;
		kpos       = bkt_ext - nneg;
		is_pos     = !is_neg && (kpos < npos);
		if (is_neg) begin
			bkt_start = SPAN_W'(1) + SPAN_W'(bucket_q) * SPAN_W'(width_eff);
		end else begin
			bkt_start = SPAN_W'(HALF_BINS)
				+ SPAN_W'(kpos[BKT_W-1:0]) * SPAN_W'(width_eff);
		end
		bkt_center = $signed(CTR_W'(bkt_start)) + $signed(CTR_W'(width_eff >> 1))
			- $signed(CTR_W'(HALF_BINS)) - $signed(CTR_W'(is_neg));
	end

	// bin RAM access per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = bin_q;
		ram_wdata = bin_inc;
		ram_re    = 1'b0;
		ram_raddr = bin_idx;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_ptr_q;
				ram_wdata = '0;
			end
			ST_ADDR: begin
				ram_re = bin_ok;
			end
			ST_RMW: begin
				ram_we = (cmd_q == CMD_ADD);
			end
			ST_SUM: begin
				ram_re    = 1'b1;
				ram_raddr = addr_q[BIN_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// moments request
	always_comb begin
		mom_upd.clear = accept && (cmd_in == CMD_CLEAR);
		mom_upd.add   = (state_q == ST_ADDR) && (cmd_q == CMD_ADD) && bin_ok;
		mom_upd.value = val_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_enable_q <= 1'b0;
			round_step_q   <= CFG_W'(2);
			bucket_width_q <= CFG_W'(10);
		end else if (cfg_we) begin
			unique case (cfg_idx_e_t'(cfg_index))
				CFG_ROUND_ENABLE: round_enable_q <= cfg_data[0];
				CFG_ROUND_STEP:   round_step_q   <= cfg_data;
				CFG_BUCKET_WIDTH: bucket_width_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cmd_q        <= CMD_CLEAR;
			report_q     <= 1'b0;
			clr_ptr_q    <= '0;
			val_q        <= '0;
			bucket_q     <= '0;
			bin_q        <= '0;
			addr_q       <= '0;
			left_q       <= '0;
			take_s1      <= 1'b0;
			acc_q        <= '0;
			nz_q         <= '0;
			res_count_q  <= '0;
			res_center_q <= '0;
			res_oor_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_count_q  <= '0;
			out_center_q <= '0;
			out_oor_q    <= 1'b0;
			out_total_q  <= '0;
			out_sum_q    <= '0;
			out_square_q <= '0;
			out_dist_q   <= '0;
		end else begin
			// result loaded when a command finishes, freed on a transfer
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				// one entry per cycle, after reset or on a clear command
				ST_CLEAR: begin
					if (clr_ptr_q == BIN_W'(NUM_BINS - 1)) begin
						clr_ptr_q <= '0;
						state_q   <= report_q ? ST_DONE : ST_IDLE;
					end else begin
						clr_ptr_q <= clr_ptr_q + BIN_W'(1);
					end
				end

				ST_IDLE: begin
					if (accept) begin
						cmd_q        <= cmd_in;
						val_q        <= VAL_W'(sample_value);
						bucket_q     <= bucket_number;
						res_count_q  <= '0;
						res_center_q <= '0;
						res_oor_q    <= 1'b0;
						unique case (cmd_in)
							CMD_CLEAR: begin
								nz_q     <= '0;
								report_q <= 1'b1;
								state_q  <= ST_CLEAR;
							end
							CMD_ADD: begin
								state_q <= need_round ? ST_DIV : ST_ADDR;
							end
							CMD_READ_BIN: begin
								state_q <= ST_ADDR;
							end
							CMD_READ_BUCKET: begin
								state_q <= ST_DIV;
							end
							default: begin
							end
						endcase
					end
				end

				ST_DIV: begin
					if (!div_busy) begin
						state_q <= (cmd_q == CMD_ADD) ? ST_SCALE : ST_BKT;
					end
				end

				// magnitude back to a multiple of the step, sign kept
				ST_SCALE: begin
					val_q   <= val_q[VAL_W-1] ? -$signed(scale_mag) : $signed(scale_mag);
					state_q <= ST_ADDR;
				end

				ST_ADDR: begin
					bin_q <= bin_idx;
					if (bin_ok) begin
						state_q <= ST_RMW;
					end else begin
						res_oor_q <= 1'b1;
						state_q   <= ST_DONE;
					end
				end

				ST_RMW: begin
					res_center_q <= CTR_OUT_W'(val_q);
					if (cmd_q == CMD_ADD) begin
						res_count_q <= bin_inc;
						if (ram_rdata == '0) begin
							nz_q <= nz_q + NZ_W'(1);
						end
					end else begin
						res_count_q <= ram_rdata;
					end
					state_q <= ST_DONE;
				end

				ST_BKT: begin
					acc_q   <= '0;
					take_s1 <= 1'b0;
					addr_q  <= bkt_start;
					left_q  <= width_eff;
					if (is_neg || is_pos) begin
						res_center_q <= CTR_OUT_W'(bkt_center);
						state_q      <= ST_SUM;
					end else begin
						res_oor_q <= 1'b1;
						state_q   <= ST_DONE;
					end
				end

				// one bin read per cycle; bins past the end add nothing
				ST_SUM: begin
					if (take_s1) begin
						acc_q <= sat_add_cnt(acc_q, ram_rdata);
					end
					take_s1 <= addr_q < SPAN_W'(NUM_BINS);
					addr_q  <= addr_q + SPAN_W'(1);
					left_q  <= left_q - CFG_W'(1);
					if (left_q == CFG_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end

				ST_DRAIN: begin
					res_count_q <= take_s1 ? sat_add_cnt(acc_q, ram_rdata) : acc_q;
					state_q     <= ST_DONE;
				end

				ST_DONE: begin
					if (out_free) begin
						out_count_q  <= res_count_q;
						out_center_q <= res_center_q;
						out_oor_q    <= res_oor_q;
						out_total_q  <= mom_tot.count;
						out_sum_q    <= mom_tot.sum;
						out_square_q <= mom_tot.square;
						out_dist_q   <= DIST_W'(nz_q);
						report_q     <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	svhm_ram #(
		.DEPTH (NUM_BINS),
		.WIDTH (CNT_W)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	svhm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	svhm_moments u_moments (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (mom_upd),
		.tot    (mom_tot)
	);

	assign out_valid           = out_valid_q;
	assign bin_or_bucket_count = out_count_q;
	assign bucket_center       = out_center_q;
	assign out_of_range        = out_oor_q;
	assign total_count         = out_total_q;
	assign value_sum           = out_sum_q;
	assign square_sum          = out_square_q;
	assign distinct_bins       = out_dist_q;

endmodule

// ===== rtl/core/svhm_checker.sv =====
// ----------------------------------------------------------------------------
// svhm_checker: port-level checks of the histogram unit
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module svhm_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_stall,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic [svhm_pkg::CNT_W-1:0]            bin_or_bucket_count,
	input logic signed [svhm_pkg::CTR_OUT_W-1:0] bucket_center,
	input logic                                  out_of_range,
	input logic [svhm_pkg::CNT_W-1:0]            total_count,
	input logic signed [svhm_pkg::SUM_W-1:0]     value_sum,
	input logic [svhm_pkg::SQ_W-1:0]             square_sum,
	input logic [svhm_pkg::DIST_W-1:0]           distinct_bins
);
	import svhm_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(bin_or_bucket_count)
			&& $stable(bucket_center) && $stable(total_count) && $stable(value_sum))
		else $error("result changed while stalled");

	// one command in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a command is in work");

	// a dropped value or missing bucket reports no count and no center
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> bin_or_bucket_count == '0 && bucket_center == '0)
		else $error("out of range result carries data");

	// empty totals are empty everywhere
	a_empty_totals: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_count == '0 |-> value_sum == '0 && square_sum == '0
			&& distinct_bins == '0)
		else $error("totals disagree with zero count");

endmodule

bind signed_value_histogram_with_moments_unit svhm_checker u_svhm_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the signed value histogram with running moments
// Drives commands and register writes into the unit and keeps its own
// histogram, totals and settings. Every command transfer queues the result
// the unit should give. Every result transfer is checked field by field
// against the oldest queued result. Directed corner cases come first, then
// random traffic under several register settings and idling patterns, then
// one heavily loaded bin read back through every bucket index.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import svhm_pkg::*;

	localparam int    QUIET_LIMIT   = 20000;	// cycles with no transfer at all
	localparam int    SETTLE_CYCLES = 4;
	localparam int    END_WAIT      = 500;
	localparam int    PHASE_ITEMS   = 145;
	localparam int    SWEEP_ADDS    = 16;
	localparam int    PRINT_LIMIT   = 100;
	localparam longint SUM_HI       = 64'sd2147483647;
	localparam longint SUM_LO       = -64'sd2147483648;
	localparam longint SQ_HI        = 64'sh00FF_FFFF_FFFF;

	typedef struct packed {
		logic        [CNT_W-1:0]     count;
		logic signed [CTR_OUT_W-1:0] center;
		logic                        oor;
		logic        [CNT_W-1:0]     total;
		logic signed [SUM_W-1:0]     vsum;
		logic        [SQ_W-1:0]      sq;
		logic        [DIST_W-1:0]    distinct;
	} hist_result_t;

	// DUT ports
	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_W-1:0]            cfg_data;
	logic                        in_valid;
	logic                        in_stall;
	logic [CMD_W-1:0]            command;
	logic signed [SMP_W-1:0]     sample_value;
	logic [BKT_W-1:0]            bucket_number;
	logic                        out_valid;
	logic                        out_stall;
	logic [CNT_W-1:0]            bin_or_bucket_count;
	logic signed [CTR_OUT_W-1:0] bucket_center;
	logic                        out_of_range;
	logic [CNT_W-1:0]            total_count;
	logic signed [SUM_W-1:0]     value_sum;
	logic [SQ_W-1:0]             square_sum;
	logic [DIST_W-1:0]           distinct_bins;

	// predicted histogram state and settings
	logic [CNT_W-1:0]        bin_count [NUM_BINS];
	logic [CNT_W-1:0]        accepted_total;
	logic signed [SUM_W-1:0] value_total;
	logic [SQ_W-1:0]         square_total;
	logic [DIST_W-1:0]       distinct_total;
	logic                    round_en_cfg     = 1'b0;
	logic [CFG_W-1:0]        round_step_cfg   = 7'd2;
	logic [CFG_W-1:0]        bucket_width_cfg = 7'd10;

	hist_result_t pending_results [$];
	int           mismatch_count = 0;
	int           result_index   = 0;
	int           quiet_cycles   = 0;
	int           idle_pct       = 0;
	int           stall_pct      = 0;

	signed_value_histogram_with_moments_unit dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.command             (command),
		.sample_value        (sample_value),
		.bucket_number       (bucket_number),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.bin_or_bucket_count (bin_or_bucket_count),
		.bucket_center       (bucket_center),
		.out_of_range        (out_of_range),
		.total_count         (total_count),
		.value_sum           (value_sum),
		.square_sum          (square_sum),
		.distinct_bins       (distinct_bins)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// histogram prediction
	// ------------------------------------------------------------------
	function automatic void clear_histogram_state();
		foreach (bin_count[i]) bin_count[i] = '0;
		accepted_total = '0;
		value_total    = '0;
		square_total   = '0;
		distinct_total = '0;
	endfunction

	// applies one command to the predicted state, returns the result it gives
	function automatic hist_result_t histogram_predict(cmd_e_t cmd, int v, int bkt);
		hist_result_t res;
		int r, b, s, m, w, nneg, npos, start, ctr, acc, i;
		longint sum_next, sq_next;
		res = '0;
		case (cmd)
			CMD_CLEAR: begin
				clear_histogram_state();
			end
			CMD_ADD: begin
				r = v;
				// magnitude rounded up from half a step, sign kept
				if (round_en_cfg) begin
					s = (round_step_cfg < 2) ? 2 : int'(round_step_cfg);
					m = (v < 0) ? -v : v;
					m = ((m + s / 2 - 1) / s) * s;
					r = (v < 0) ? -m : m;
				end
				b = r + HALF_BINS;
				if (b < 0 || b >= NUM_BINS) begin
					res.oor = 1'b1;
				end else begin
					if (bin_count[b] == '0) distinct_total++;
					if (bin_count[b] != CNT_MAX) bin_count[b]++;
					res.count  = bin_count[b];
					res.center = CTR_OUT_W'(r);
					if (accepted_total != CNT_MAX) accepted_total++;
					sum_next = longint'(value_total) + r;
					if (sum_next > SUM_HI) sum_next = SUM_HI;
					if (sum_next < SUM_LO) sum_next = SUM_LO;
					value_total = SUM_W'(sum_next);
					sq_next = longint'(square_total) + longint'(r) * r;
					if (sq_next > SQ_HI) sq_next = SQ_HI;
					square_total = SQ_W'(sq_next);
				end
			end
			CMD_READ_BIN: begin
				b = v + HALF_BINS;
				if (b < 0 || b >= NUM_BINS) begin
					res.oor = 1'b1;
				end else begin
					res.count  = bin_count[b];
					res.center = CTR_OUT_W'(v);
				end
			end
			default: begin
				// negative-side buckets from bin 1, then positive ones from the zero bin
				w     = (bucket_width_cfg == 0) ? 1 : int'(bucket_width_cfg);
				nneg  = (HALF_BINS - 1 + w - 1) / w;
				npos  = (HALF_BINS - w > 0) ? (HALF_BINS - 1) / w : 0;
				start = -1;
				if (bkt < nneg) begin
					start = 1 + bkt * w;
					ctr   = start + w / 2 - HALF_BINS - 1;
				end else if (bkt < nneg + npos) begin
					start = HALF_BINS + (bkt - nneg) * w;
					ctr   = start + w / 2 - HALF_BINS;
				end else begin
					res.oor = 1'b1;
				end
				if (start >= 0) begin
					acc = 0;
					for (i = 0; i < w; i++)
						if (start + i < NUM_BINS) acc += bin_count[start + i];
					res.count  = (acc > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(acc);
					res.center = CTR_OUT_W'(ctr);
				end
			end
		endcase
		res.total    = accepted_total;
		res.vsum     = value_total;
		res.sq       = square_total;
		res.distinct = distinct_total;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [SQ_W-1:0] got,
		input logic [SQ_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t ns: result %0d %s: got %0h, expected %0h",
				$realtime, result_index, what, got, want);
	endtask

	// tracks register writes, checks result transfers, predicts command transfers
	always @(posedge clk) begin : result_check
		hist_result_t got, want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_idx_e_t'(cfg_index))
					CFG_ROUND_ENABLE: round_en_cfg     = cfg_data[0];
					CFG_ROUND_STEP:   round_step_cfg   = cfg_data;
					CFG_BUCKET_WIDTH: bucket_width_cfg = cfg_data;
					default: ;
				endcase
			end
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got.count    = bin_or_bucket_count;
				got.center   = bucket_center;
				got.oor      = out_of_range;
				got.total    = total_count;
				got.vsum     = value_sum;
				got.sq       = square_sum;
				got.distinct = distinct_bins;
				if (pending_results.size() == 0) begin
					report_mismatch("transfer with no result pending", got.count, '0);
				end else begin
					want = pending_results.pop_front();
					if (got.count !== want.count)
						report_mismatch("bin_or_bucket_count", got.count, want.count);
					if (got.center !== want.center)
						report_mismatch("bucket_center", got.center, want.center);
					if (got.oor !== want.oor)
						report_mismatch("out_of_range", got.oor, want.oor);
					if (got.total !== want.total)
						report_mismatch("total_count", got.total, want.total);
					if (got.vsum !== want.vsum)
						report_mismatch("value_sum", got.vsum, want.vsum);
					if (got.sq !== want.sq)
						report_mismatch("square_sum", got.sq, want.sq);
					if (got.distinct !== want.distinct)
						report_mismatch("distinct_bins", got.distinct, want.distinct);
				end
				result_index++;
			end
			if (in_valid === 1'b1 && in_stall === 1'b0)
				pending_results.push_back(histogram_predict(cmd_e_t'(command),
					sample_value, bucket_number));
		end
	end

	// watchdog: ends the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
			(out_valid === 1'b1 && out_stall === 1'b0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t ns: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver stalls at random, at the rate of the current phase
	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	// one command transfer; valid stays high on return for back-to-back items
	task automatic send_command(input cmd_e_t cmd, input int value, input int bkt);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid      = 1'b1;
		command       = cmd;
		sample_value  = SMP_W'(value);
		bucket_number = BKT_W'(bkt);
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// sender holds off until every pending result has arrived
	task automatic wait_results_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// all three registers, written only while the unit is idle
	task automatic apply_settings(input logic en, input logic [CFG_W-1:0] step,
		input logic [CFG_W-1:0] width);
		wait_results_drained();
		cfg_we    = 1'b1;
		cfg_index = CFG_ROUND_ENABLE;
		cfg_data  = {6'($urandom_range(63)), en};	// upper bits are don't-care
		@(negedge clk);
		cfg_index = CFG_ROUND_STEP;
		cfg_data  = step;
		@(negedge clk);
		cfg_index = CFG_BUCKET_WIDTH;
		cfg_data  = width;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// field extremes, every command and each corner case
	task automatic test_directed_cases();
		idle_pct  = 0;
		stall_pct = 0;
		// reset settings: no rounding, ten bins per bucket
		send_command(CMD_READ_BIN, 0, 0);
		send_command(CMD_ADD, -32768, 63);
		send_command(CMD_ADD, 32767, 0);
		send_command(CMD_ADD, -HALF_BINS, 0);
		send_command(CMD_ADD, HALF_BINS - 1, 0);
		send_command(CMD_ADD, -HALF_BINS - 1, 0);
		send_command(CMD_ADD, HALF_BINS, 0);
		send_command(CMD_ADD, 0, 0);
		send_command(CMD_READ_BIN, -HALF_BINS, 0);
		send_command(CMD_READ_BIN, HALF_BINS - 1, 0);
		send_command(CMD_READ_BIN, HALF_BINS, 0);
		send_command(CMD_READ_BIN, -32768, 0);
		send_command(CMD_READ_BUCKET, 0, 0);
		send_command(CMD_READ_BUCKET, 0, 19);
		send_command(CMD_READ_BUCKET, 0, 20);
		send_command(CMD_READ_BUCKET, 0, 38);
		send_command(CMD_READ_BUCKET, 0, 39);
		send_command(CMD_READ_BUCKET, -1, 63);
		// step below two and zero width
		apply_settings(1'b1, 7'd0, 7'd0);
		send_command(CMD_ADD, 3, 0);
		send_command(CMD_ADD, -199, 0);
		send_command(CMD_READ_BUCKET, 0, 0);
		// widest step and width
		apply_settings(1'b1, 7'd127, 7'd127);
		send_command(CMD_ADD, 100, 0);
		send_command(CMD_ADD, -150, 0);
		send_command(CMD_ADD, 199, 0);
		send_command(CMD_READ_BUCKET, 0, 2);
		send_command(CMD_CLEAR, 32767, 63);
	endtask

	// random commands under one register setting and one idling pattern
	task automatic test_random_traffic(input int phase_idx);
		int n, sel, value;
		case (phase_idx)
			0:       apply_settings(1'b0, 7'd2, 7'd10);
			1:       apply_settings(1'b1, 7'd0, 7'd0);
			2:       apply_settings(1'b1, 7'd127, 7'd127);
			3:       apply_settings(1'b1, 7'd64, 7'd64);
			4:       apply_settings(1'b0, 7'd1, 7'd1);
			default: apply_settings(1'($urandom_range(1)), 7'($urandom_range(127)),
				7'($urandom_range(127)));
		endcase
		case (phase_idx % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 87; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 87; end
			default: begin idle_pct = 28; stall_pct = 28; end
		endcase
		for (n = 0; n < PHASE_ITEMS; n++) begin
			// mostly values near the bins, some across the whole input range
			if ($urandom_range(99) < 85)
				value = int'($urandom_range(520)) - 260;
			else
				value = int'($signed(16'($urandom())));
			sel = $urandom_range(99);
			if (sel < 1)
				send_command(CMD_CLEAR, value, $urandom_range(63));
			else if (sel < 51)
				send_command(CMD_ADD, value, $urandom_range(63));
			else if (sel < 71)
				send_command(CMD_READ_BIN, value, $urandom_range(63));
			else
				send_command(CMD_READ_BUCKET, value, $urandom_range(63));
			if ($urandom_range(49) == 0) wait_results_drained();
		end
	endtask

	// one bin loaded well above its neighbor, then every bucket index read
	task automatic test_bucket_sweep();
		int n, low_val;
		apply_settings(1'b0, 7'd2, 7'd10);
		idle_pct  = 0;
		stall_pct = 0;
		low_val   = int'($urandom_range(HALF_BINS * 2 - 2)) - HALF_BINS;
		send_command(CMD_CLEAR, 0, 0);
		for (n = 0; n < SWEEP_ADDS; n++)
			send_command(CMD_ADD, low_val, 0);
		for (n = 0; n < 3; n++)
			send_command(CMD_ADD, low_val + 1, 0);
		send_command(CMD_READ_BIN, low_val, 0);
		send_command(CMD_READ_BIN, low_val + 1, 0);
		for (n = 0; n < 64; n++)
			send_command(CMD_READ_BUCKET, 0, n);
		send_command(CMD_CLEAR, 0, 0);
		send_command(CMD_READ_BIN, low_val, 0);
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_ROUND_ENABLE;
		cfg_data      = '0;
		in_valid      = 1'b0;
		command       = CMD_CLEAR;
		sample_value  = '0;
		bucket_number = '0;
		clear_histogram_state();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		for (int p = 0; p < 8; p++)
			test_random_traffic(p);
		test_bucket_sweep();

		wait_results_drained();
		repeat (END_WAIT) @(negedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
